// ===== src/message_fragment_reassembly_macros.svh =====
// ----------------------------------------------------------------------------
// Message fragment reassembly: assertion macros
// Concurrent assertion wrappers shared by the reassembly RTL. They expand to
// nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_FRAGMENT_REASSEMBLY_MACROS_SVH
`define MESSAGE_FRAGMENT_REASSEMBLY_MACROS_SVH
`ifndef SYNTHESIS
`define MFR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MFR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MFR_ASSERT(label, clk, rst, prop, msg)
`define MFR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== src/mfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Message fragment reassembly package
// Beat types, field widths, codes and default sizes shared by the block.
// ----------------------------------------------------------------------------
package mfr_pkg;

  localparam int SLOT_COUNT_DEFAULT        = 8;
  localparam int MAX_MESSAGE_BYTES_DEFAULT = 4096;

  localparam int ID_W    = 16;
  localparam int FRAG_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int RSLOT_W = 3;
  localparam int ROFF_W  = 12;
  localparam int RKIND_W = 2;
  localparam int OSLOT_W = 3;
  localparam int MLEN_W  = 12;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [RKIND_W-1:0] RES_COMPLETE = 2'd0;
  localparam logic [RKIND_W-1:0] RES_DROPPED  = 2'd1;
  localparam logic [RKIND_W-1:0] RES_READ     = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   msg_id;
    logic [FRAG_W-1:0] frag_index;
    logic [FRAG_W-1:0] frag_len;
    logic [BYTE_W-1:0] data_byte;
    logic [RSLOT_W-1:0] read_slot;
    logic [ROFF_W-1:0] read_offset;
  } frag_beat_t;

  typedef struct packed {
    logic [RKIND_W-1:0] result_kind;
    logic [OSLOT_W-1:0] slot;
    logic [MLEN_W-1:0]  msg_length;
    logic [BYTE_W-1:0]  read_data;
  } res_beat_t;

  typedef struct packed {
    logic wr;
    logic clear;
    logic claim;
  } tbl_cmd_t;

endpackage

// ===== src/mfr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module mfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/mfr_slot_table.sv =====
// ----------------------------------------------------------------------------
// Reassembly slot table
// Per-slot active flag, message id and fill level, with a parallel id lookup
// that picks the matching slot, else the first free slot, else slot zero.
// ----------------------------------------------------------------------------
`include "message_fragment_reassembly_macros.svh"

module mfr_slot_table import mfr_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
  parameter int USED_W     = 13,
  localparam int SW = $clog2(SLOT_COUNT)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ID_W-1:0]       lookup_id,
  output logic [SW-1:0]         pick_slot,
  output logic [USED_W-1:0]     pick_used,
  input  logic [SW-1:0]         cur_slot,
  output logic [USED_W-1:0]     cur_used,
  output logic [SLOT_COUNT-1:0] active,
  input  tbl_cmd_t              cmd,
  input  logic [SW-1:0]         cmd_slot,
  input  logic [ID_W-1:0]       cmd_id,
  input  logic [USED_W-1:0]     cmd_used
);

  logic [ID_W-1:0]       ids  [SLOT_COUNT];
  logic [USED_W-1:0]     used [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] match;
  logic                  hit;
  logic                  found_free;
  logic [SW-1:0]         hit_idx;
  logic [SW-1:0]         free_idx;

  always_comb begin
    hit        = 1'b0;
    found_free = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    pick_used  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match[i] = active[i] && (ids[i] == lookup_id);
      if (match[i] && !hit) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
      if (!active[i] && !found_free) begin
        found_free = 1'b1;
        free_idx   = SW'(i);
      end
      if (match[i]) begin
        pick_used = pick_used | used[i];
      end
    end
    if (hit) begin
      pick_slot = hit_idx;
    end else if (found_free) begin
      pick_slot = free_idx;
    end else begin
      pick_slot = '0;
    end
  end

  assign cur_used = used[cur_slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        ids[i]  <= '0;
        used[i] <= '0;
      end
    end else if (cmd.wr) begin
      if (cmd.clear) begin
        active[cmd_slot] <= 1'b0;
        ids[cmd_slot]    <= '0;
        used[cmd_slot]   <= '0;
      end else begin
        if (cmd.claim) begin
          active[cmd_slot] <= 1'b1;
          ids[cmd_slot]    <= cmd_id;
        end
        used[cmd_slot] <= cmd_used;
      end
    end
  end

  `MFR_ASSERT(a_unique_id, clk, rst, $onehot0(match), "Two active slots share one message id.")
  `MFR_ASSERT(a_claim_free, clk, rst, (cmd.wr && cmd.claim && !cmd.clear && !hit && found_free) |-> !active[cmd_slot], "A new message was placed in a busy slot.")

endmodule

// ===== src/message_fragment_reassembly.sv =====
// ----------------------------------------------------------------------------
// Message fragment reassembly
// Rebuilds messages from byte-wide fragment beats in a set of slots keyed by
// message id, reports completed and dropped messages, and reads back bytes.
//
//   Channel  Direction  Handshake                Beat
//   frag     in         frag_valid / frag_ready  frag_beat_t
//   res      out        res_valid / res_ready    res_beat_t
//
// One beat is accepted per cycle while frag_ready is high; slot lookup, table
// update and the store write all happen in the accepting cycle, and read data
// is ready in the next cycle. A result sits in a holding stage and then in the
// output register, so input stalls only when both are full and the output is
// stalled. Reset is synchronous; the slot table is cleared at once and the
// message store needs no clearing pass.
// ----------------------------------------------------------------------------
`include "message_fragment_reassembly_macros.svh"

module message_fragment_reassembly import mfr_pkg::*; #(
  parameter int SLOT_COUNT        = SLOT_COUNT_DEFAULT,
  parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       frag_valid,
  output logic       frag_ready,
  input  frag_beat_t frag,
  output logic       res_valid,
  input  logic       res_ready,
  output res_beat_t  res
);

  localparam int SW     = $clog2(SLOT_COUNT);
  localparam int USED_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int DEPTH  = SLOT_COUNT * MAX_MESSAGE_BYTES;
  localparam int AW     = $clog2(DEPTH);
  localparam int SUM_W  = (USED_W > FRAG_W ? USED_W : FRAG_W) + 2;

  logic [FRAG_W-1:0]     frag_count;
  logic [SW-1:0]         cur_slot;
  logic                  cur_drop;

  logic [SW-1:0]         pick_slot;
  logic [USED_W-1:0]     pick_used;
  logic [USED_W-1:0]     cur_used;
  logic [SLOT_COUNT-1:0] slot_active;
  tbl_cmd_t              cmd;

  logic                  fire;
  logic                  is_read;
  logic                  is_append;
  logic                  first;
  logic [SW-1:0]         slot_eff;
  logic [USED_W-1:0]     used_base;
  logic [USED_W-1:0]     used_new;
  logic                  over;
  logic                  drop_now;
  logic                  drop_eff;
  logic                  do_write;
  logic                  last;
  logic                  complete;
  logic                  rd_in_range;
  logic                  has_result;
  logic [31:0]           slot_ext;
  logic [31:0]           used_ext;

  logic                  ram_wr;
  logic [AW-1:0]         ram_wr_addr;
  logic                  ram_rd;
  logic [AW-1:0]         ram_rd_addr;
  logic [BYTE_W-1:0]     ram_rdata;

  logic                  p_valid;
  logic                  p_rd;
  res_beat_t             p_beat;
  res_beat_t             p_beat_next;
  logic                  p_move;

  assign fire      = frag_valid && frag_ready;
  assign is_read   = frag.kind == KIND_READ;
  assign is_append = frag.kind == KIND_APPEND && frag.frag_len != '0;
  assign first     = frag_count == '0;
  assign slot_eff  = first ? pick_slot : cur_slot;
  assign used_base = first ? pick_used : cur_used;
  assign over      = SUM_W'(used_base) + SUM_W'(frag.frag_len) + SUM_W'(1)
                     > SUM_W'(MAX_MESSAGE_BYTES);
  assign drop_now  = first && over;
  assign drop_eff  = first ? over : cur_drop;
  assign do_write  = !drop_eff && (SUM_W'(used_base) < SUM_W'(MAX_MESSAGE_BYTES));
  assign used_new  = do_write ? used_base + USED_W'(1) : used_base;
  assign last      = ({1'b0, frag_count} + (FRAG_W + 1)'(1)) >= {1'b0, frag.frag_len};
  assign complete  = last && !drop_eff && frag.frag_index == '0;
  assign slot_ext  = 32'(slot_eff);
  assign used_ext  = 32'(used_new);

  assign rd_in_range = (32'(frag.read_slot) < 32'(SLOT_COUNT))
                    && (32'(frag.read_offset) < 32'(MAX_MESSAGE_BYTES));

  assign cmd.wr    = fire && is_append;
  assign cmd.clear = drop_now || complete;
  assign cmd.claim = first;

  mfr_slot_table #(
    .SLOT_COUNT (SLOT_COUNT),
    .USED_W     (USED_W)
  ) u_slot_table (
    .clk       (clk),
    .rst       (rst),
    .lookup_id (frag.msg_id),
    .pick_slot (pick_slot),
    .pick_used (pick_used),
    .cur_slot  (cur_slot),
    .cur_used  (cur_used),
    .active    (slot_active),
    .cmd       (cmd),
    .cmd_slot  (slot_eff),
    .cmd_id    (frag.msg_id),
    .cmd_used  (used_new)
  );

  assign ram_wr      = fire && is_append && do_write;
  assign ram_wr_addr = AW'(slot_eff) * AW'(MAX_MESSAGE_BYTES) + AW'(used_base);
  assign ram_rd      = fire && is_read && rd_in_range;
  assign ram_rd_addr = AW'(frag.read_slot) * AW'(MAX_MESSAGE_BYTES) + AW'(frag.read_offset);

  mfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (ram_wr_addr),
    .wr_data (frag.data_byte),
    .rd_en   (ram_rd),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frag_count <= '0;
      cur_slot   <= '0;
      cur_drop   <= 1'b0;
    end else if (fire && is_append) begin
      frag_count <= last ? '0 : frag_count + FRAG_W'(1);
      cur_slot   <= slot_eff;
      cur_drop   <= last ? 1'b0 : drop_eff;
    end
  end

  assign has_result = fire && (is_read || (is_append && (drop_now || complete)));

  always_comb begin
    p_beat_next.read_data = '0;
    if (is_read) begin
      p_beat_next.result_kind = RES_READ;
      p_beat_next.slot        = frag.read_slot;
      p_beat_next.msg_length  = '0;
    end else if (drop_now) begin
      p_beat_next.result_kind = RES_DROPPED;
      p_beat_next.slot        = slot_ext[OSLOT_W-1:0];
      p_beat_next.msg_length  = '0;
    end else begin
      p_beat_next.result_kind = RES_COMPLETE;
      p_beat_next.slot        = slot_ext[OSLOT_W-1:0];
      p_beat_next.msg_length  = used_ext[MLEN_W-1:0];
    end
  end

  assign p_move     = p_valid && (!res_valid || res_ready);
  assign frag_ready = !p_valid || p_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (frag_ready) begin
      p_valid <= has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (frag_ready) begin
      p_beat <= p_beat_next;
      p_rd   <= is_read && rd_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (p_move) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      res <= {p_beat.result_kind, p_beat.slot, p_beat.msg_length,
              (p_rd ? ram_rdata : BYTE_W'(0))};
    end
  end

  `MFR_ASSERT(a_rdata_held, clk, rst, (p_valid && p_rd && !p_move) |=> $stable(ram_rdata), "Read data changed while its result was stalled.")
  `MFR_ASSERT(a_slot_live, clk, rst, (frag_count != '0 && !cur_drop) |-> slot_active[cur_slot], "The slot of an open fragment is not active.")
  `MFR_ASSERT(a_stall_full, clk, rst, !frag_ready |-> (p_valid && res_valid), "Input stalled with a free result stage.")
  `MFR_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!p_valid && !res_valid), "Result stages not empty after reset.")

endmodule
